// ===== design/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, codes and saturating Q-format helpers for the root finder.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

    typedef logic signed [63:0] t_word;
    typedef logic        [63:0] t_umag;

    // Beat layouts
    typedef struct packed {
        logic  op;
        t_word x_low;
        t_word x_high;
        t_word f_low;
        t_word f_high;
        t_word f_value;
    } t_in_beat;

    typedef struct packed {
        logic        kind;
        t_word       point;
        logic [15:0] iterations;
        logic        iterations_valid;
    } t_out_beat;

    // Input op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    // Result kinds
    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_ROOT  = 1'b1;

    // Config register indexes
    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_MAX_ITER  = 1'b1;

    localparam t_word SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_word SMIN = 64'sh8000_0000_0000_0000;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_BISECT = 2'd1,
        MODE_BRENT  = 2'd2
    } t_mode;

    function automatic t_word sadd(input t_word a, input t_word b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? SMIN : SMAX;
        end
        return s[63:0];
    endfunction

    function automatic t_word ssub(input t_word a, input t_word b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? SMIN : SMAX;
        end
        return s[63:0];
    endfunction

    function automatic t_word sneg(input t_word x);
        return (x == SMIN) ? SMAX : -x;
    endfunction

    function automatic t_word sabs(input t_word x);
        return x[63] ? sneg(x) : x;
    endfunction

    function automatic t_umag mag(input t_word x);
        return x[63] ? t_umag'(-x) : t_umag'(x);
    endfunction

    // sign and magnitude back to two's complement, clamped to +-SMAX
    function automatic t_word signed_mag(input logic neg, input t_umag m);
        t_umag c;
        c = m[63] ? t_umag'(SMAX) : m;
        return neg ? -t_word'(c) : t_word'(c);
    endfunction

    // floor((a+b)/2)
    function automatic t_word midpoint(input t_word a, input t_word b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        return s[64:1];
    endfunction

    // floor((c-b)/2)
    function automatic t_word half_diff(input t_word c, input t_word b);
        logic [64:0] d;
        d = {c[63], c} - {b[63], b};
        return d[64:1];
    endfunction

    function automatic t_umag udist(input t_word a, input t_word b);
        logic [64:0] d;
        d = {a[63], a} - {b[63], b};
        return d[64] ? t_umag'(-d) : d[63:0];
    endfunction

    function automatic logic is_pos(input t_word x);
        return !x[63] && (x != '0);
    endfunction

    function automatic logic same_sign(input t_word a, input t_word b);
        return (is_pos(a) && is_pos(b)) || (a[63] && b[63]);
    endfunction

endpackage

`default_nettype wire

// ===== design/brf_ifs.sv =====
// ----------------------------------------------------------------------------
// brf_ifs
// Valid/ready channels for the root finder input and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface brf_in_if;
    logic             valid;
    logic             ready;
    brf_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brf_out_if;
    logic              valid;
    logic              ready;
    brf_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/brf_alu.sv =====
// ----------------------------------------------------------------------------
// brf_alu
// Shared multicycle Q-format unit: multiply from four 32x32 partial products,
// divide by restoring long division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_alu #(
    parameter int FRAC_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire brf_pkg::t_alu_op i_op,
    input  wire brf_pkg::t_word   i_a,
    input  wire brf_pkg::t_word   i_b,
    output logic                  o_done,
    output brf_pkg::t_word        o_res
);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_FIN  = 4'b1000
    } t_alu_st;

    t_alu_st          r_st, n_st;
    logic             r_done, n_done;
    brf_pkg::t_alu_op r_op, n_op;
    logic             r_neg, n_neg;
    logic             r_sat, n_sat;
    brf_pkg::t_umag   r_ua, n_ua;
    brf_pkg::t_umag   r_ub, n_ub;
    logic [127:0]     r_acc, n_acc;
    logic [64:0]      r_rem, n_rem;
    brf_pkg::t_umag   r_lo, n_lo;
    brf_pkg::t_umag   r_q, n_q;
    logic [5:0]       r_cnt, n_cnt;
    brf_pkg::t_word   r_res, n_res;

    brf_pkg::t_umag   un, ud, hi;
    logic [31:0]      a_half, b_half;
    logic [63:0]      pprod;
    logic [6:0]       shamt;
    logic [64:0]      rs;
    logic             fin_sat;
    brf_pkg::t_umag   fin_mag;

    always_comb begin
        n_st   = r_st;
        n_done = 1'b0;
        n_op   = r_op;
        n_neg  = r_neg;
        n_sat  = r_sat;
        n_ua   = r_ua;
        n_ub   = r_ub;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_res  = r_res;

        un = brf_pkg::mag(i_a);
        ud = brf_pkg::mag(i_b);
        hi = un >> (64 - FRAC_BITS);

        a_half = r_cnt[0] ? r_ua[63:32] : r_ua[31:0];
        b_half = r_cnt[1] ? r_ub[63:32] : r_ub[31:0];
        pprod  = a_half * b_half;
        shamt  = {r_cnt[0] & r_cnt[1], r_cnt[0] ^ r_cnt[1], 5'b0};
        rs     = {r_rem[63:0], r_lo[63]};

        fin_sat = (r_op == brf_pkg::ALU_MUL) ? (|r_acc[127:64+FRAC_BITS]) : r_sat;
        fin_mag = (r_op == brf_pkg::ALU_MUL) ? r_acc[FRAC_BITS+63 -: 64] : r_q;

        unique case (r_st)
            A_IDLE: begin
                if (i_start) begin
                    n_op  = i_op;
                    n_neg = i_a[63] != i_b[63];
                    n_cnt = '0;
                    n_sat = 1'b0;
                    n_q   = '0;
                    if (i_op == brf_pkg::ALU_MUL) begin
                        n_ua  = un;
                        n_ub  = ud;
                        n_acc = '0;
                        n_st  = A_MUL;
                    end else if (un == '0) begin
                        n_st = A_FIN;
                    end else if (ud == '0 || hi >= ud) begin
                        n_sat = 1'b1;
                        n_st  = A_FIN;
                    end else begin
                        n_ub  = ud;
                        n_rem = {1'b0, hi};
                        n_lo  = un << FRAC_BITS;
                        n_st  = A_DIV;
                    end
                end
            end
            A_MUL: begin
                n_acc = r_acc + ({64'b0, pprod} << shamt);
                n_cnt = r_cnt + 6'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_st = A_FIN;
                end
            end
            A_DIV: begin
                n_lo = r_lo << 1;
                if (rs >= {1'b0, r_ub}) begin
                    n_rem = rs - {1'b0, r_ub};
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = rs;
                    n_q   = {r_q[62:0], 1'b0};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_st = A_FIN;
                end
            end
            A_FIN: begin
                n_res  = brf_pkg::signed_mag(r_neg, fin_sat ? '1 : fin_mag);
                n_done = 1'b1;
                n_st   = A_IDLE;
            end
            default: n_st = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= A_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_neg <= n_neg;
        r_sat <= n_sat;
        r_ua  <= n_ua;
        r_ub  <= n_ub;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_q   <= n_q;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== design/brent_root_finder_core.sv =====
// ----------------------------------------------------------------------------
// brent_root_finder_core
// Brent-Dekker root-finding sequencer, signed Q(64-F).F fixed point.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake           beat
//  ---------  ---  ------------------  ----------------------------------------
//  i_item     in   valid/ready         op, x_low, x_high, f_low, f_high, f_value
//  o_result   out  valid/ready         kind, point, iterations, iterations_valid
//  i_cfg_*    in   write enable only   0 tolerance, 1 max_iterations
//
//  Steps: a start passes S_START and S_EMIT, a bisection reply S_BIS, S_BIS2
//  and S_EMIT. A Brent step runs on one shared mul/div unit; a full
//  inverse-quadratic step issues 4 divides and 9 multiplies in turn, a
//  bisection fallback from S_B3 none. The divider gives one bit per cycle.
//  Reset: synchronous, active low; the search goes idle and the registers
//  return to tolerance 4295, max_iterations 0.
//  Stalls: one beat is worked at a time; i_item is ready whenever the
//  sequencer is idle, also while a result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brent_root_finder_core #(
    parameter int FRAC_BITS            = 32,
    parameter int DEFAULT_BISECT_ITERS = 50,
    parameter int DEFAULT_BRENT_ITERS  = 100
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    brf_in_if.sink     i_item,
    brf_out_if.source  o_result,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [62:0] i_cfg_data
);

    localparam brf_pkg::t_word Q_ONE = brf_pkg::t_word'(64'd1 << FRAC_BITS);

    typedef enum logic [26:0] {
        S_IDLE  = 27'h0000001,
        S_START = 27'h0000002,
        S_BIS   = 27'h0000004,
        S_BIS2  = 27'h0000008,
        S_BRCHK = 27'h0000010,
        S_B0    = 27'h0000020,
        S_B1    = 27'h0000040,
        S_B2    = 27'h0000080,
        S_B3    = 27'h0000100,
        S_DS    = 27'h0000200,
        S_P0    = 27'h0000400,
        S_DQ1   = 27'h0000800,
        S_DR    = 27'h0001000,
        S_M1    = 27'h0002000,
        S_M2    = 27'h0004000,
        S_M3    = 27'h0008000,
        S_M4    = 27'h0010000,
        S_M5    = 27'h0020000,
        S_M6    = 27'h0040000,
        S_SIGN  = 27'h0080000,
        S_L1    = 27'h0100000,
        S_L2    = 27'h0200000,
        S_L3    = 27'h0400000,
        S_CMP   = 27'h0800000,
        S_DD    = 27'h1000000,
        S_FIN   = 27'h2000000,
        S_EMIT  = 27'h4000000
    } t_state;

    // control
    t_state         r_state, n_state;
    brf_pkg::t_mode r_mode, n_mode;
    logic           r_wait, n_wait;
    logic           r_ovalid, n_ovalid;
    logic [62:0]    r_tol, n_tol;
    logic [15:0]    r_maxit, n_maxit;

    // search state and scratch
    brf_pkg::t_word r_a, n_a, r_b, n_b, r_c, n_c;
    brf_pkg::t_word r_fa, n_fa, r_fb, n_fb, r_fc, n_fc;
    brf_pkg::t_word r_d, n_d, r_e, n_e;
    brf_pkg::t_word r_xm, n_xm, r_s, n_s, r_q1, n_q1, r_rr, n_rr;
    brf_pkg::t_word r_t, n_t, r_p, n_p, r_q, n_q, r_lim1, n_lim1;
    brf_pkg::t_word r_fv, n_fv;
    logic [15:0]    r_iter, n_iter;
    brf_pkg::t_out_beat r_pend, n_pend;
    brf_pkg::t_out_beat r_odata, n_odata;

    // shared arithmetic unit
    logic             alu_start, alu_done;
    brf_pkg::t_alu_op alu_op;
    brf_pkg::t_word   alu_a, alu_b, alu_res;

    logic           in_acc, out_free, is_arith, step_done;
    logic [15:0]    lim_bis, lim_brent, iter_inc;
    brf_pkg::t_umag tol1;
    brf_pkg::t_word tol1_s, mid_ab, pp, lim_min, new_b;

    brf_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    assign i_item.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_ovalid;
    assign o_result.data  = r_odata;

    assign in_acc   = i_item.valid && i_item.ready;
    assign out_free = !r_ovalid || o_result.ready;

    // tol1 = 1 + tolerance/2 (relative term is one LSB)
    assign tol1    = {2'b0, r_tol[62:1]} + 64'd1;
    assign tol1_s  = brf_pkg::t_word'(tol1);
    assign mid_ab  = brf_pkg::midpoint(r_a, r_b);
    assign iter_inc = r_iter + 16'd1;
    assign lim_bis   = (r_maxit != '0) ? r_maxit : 16'(DEFAULT_BISECT_ITERS);
    assign lim_brent = (r_maxit != '0) ? r_maxit : 16'(DEFAULT_BRENT_ITERS);

    assign step_done = r_wait && alu_done;
    assign alu_start = is_arith && !r_wait;

    always_comb begin
        case (r_state) inside
            S_DS, S_P0, S_DQ1, S_DR, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
            S_L1, S_L2, S_L3, S_DD: is_arith = 1'b1;
            default:                is_arith = 1'b0;
        endcase
    end

    // operand select for the shared unit
    always_comb begin
        alu_op = brf_pkg::ALU_MUL;
        alu_a  = '0;
        alu_b  = '0;
        unique case (r_state)
            S_DS: begin
                alu_op = brf_pkg::ALU_DIV; alu_a = r_fb; alu_b = r_fa;
            end
            S_DQ1: begin
                alu_op = brf_pkg::ALU_DIV; alu_a = r_fa; alu_b = r_fc;
            end
            S_DR: begin
                alu_op = brf_pkg::ALU_DIV; alu_a = r_fb; alu_b = r_fc;
            end
            S_DD: begin
                alu_op = brf_pkg::ALU_DIV; alu_a = r_p; alu_b = r_q;
            end
            S_P0: begin
                alu_a = brf_pkg::sadd(r_xm, r_xm); alu_b = r_s;
            end
            S_M1: begin
                alu_a = brf_pkg::sadd(r_xm, r_xm); alu_b = r_q1;
            end
            S_M2: begin
                alu_a = r_t; alu_b = brf_pkg::ssub(r_q1, r_rr);
            end
            S_M3: begin
                alu_a = brf_pkg::ssub(r_b, r_a); alu_b = brf_pkg::ssub(r_rr, Q_ONE);
            end
            S_M4: begin
                alu_a = r_s; alu_b = brf_pkg::ssub(r_t, r_p);
            end
            S_M5: begin
                alu_a = brf_pkg::ssub(r_q1, Q_ONE); alu_b = brf_pkg::ssub(r_rr, Q_ONE);
            end
            S_M6: begin
                alu_a = r_q; alu_b = brf_pkg::ssub(r_s, Q_ONE);
            end
            S_L1: begin
                alu_a = brf_pkg::sadd(brf_pkg::sadd(r_xm, r_xm), r_xm); alu_b = r_q;
            end
            S_L2: begin
                alu_a = tol1_s; alu_b = r_q;
            end
            S_L3: begin
                alu_a = r_e; alu_b = r_q;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_wait   = is_arith ? (r_wait ? !alu_done : 1'b1) : 1'b0;
        n_ovalid = r_ovalid && !o_result.ready;
        n_tol    = r_tol;
        n_maxit  = r_maxit;
        n_a = r_a;   n_b = r_b;   n_c = r_c;
        n_fa = r_fa; n_fb = r_fb; n_fc = r_fc;
        n_d = r_d;   n_e = r_e;
        n_xm = r_xm; n_s = r_s; n_q1 = r_q1; n_rr = r_rr;
        n_t = r_t;   n_p = r_p; n_q = r_q;   n_lim1 = r_lim1;
        n_fv = r_fv;
        n_iter  = r_iter;
        n_pend  = r_pend;
        n_odata = r_odata;
        pp      = brf_pkg::sadd(r_p, r_p);
        lim_min = (r_lim1 < r_t) ? r_lim1 : r_t;
        new_b   = (brf_pkg::mag(r_d) > tol1) ? brf_pkg::sadd(r_b, r_d)
                : brf_pkg::sadd(r_b, brf_pkg::is_pos(r_xm) ? tol1_s : -tol1_s);

        if (i_cfg_we) begin
            if (i_cfg_idx == brf_pkg::CFG_TOLERANCE) begin
                n_tol = i_cfg_data;
            end else begin
                n_maxit = i_cfg_data[15:0];
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_item.data.op == brf_pkg::OP_START) begin
                        n_a  = i_item.data.x_low;
                        n_b  = i_item.data.x_high;
                        n_c  = i_item.data.x_high;
                        n_fa = i_item.data.f_low;
                        n_fb = i_item.data.f_high;
                        n_fc = i_item.data.f_high;
                        n_d  = '0;
                        n_e  = '0;
                        n_iter  = '0;
                        n_state = S_START;
                    end else if (r_mode == brf_pkg::MODE_BISECT) begin
                        n_fv    = i_item.data.f_value;
                        n_state = S_BIS;
                    end else if (r_mode == brf_pkg::MODE_BRENT) begin
                        n_fb    = i_item.data.f_value;
                        n_iter  = iter_inc;
                        n_state = S_BRCHK;
                    end
                    // reply with no search running: dropped, no result
                end
            end
            S_START: begin
                n_state = S_EMIT;
                if (r_fa == '0) begin
                    n_pend = '{brf_pkg::KIND_ROOT, r_a, 16'd0, 1'b0};
                end else if (r_fb == '0) begin
                    n_pend = '{brf_pkg::KIND_ROOT, r_b, 16'd0, 1'b0};
                end else if (brf_pkg::same_sign(r_fa, r_fb)) begin
                    // no sign change: plain bisection
                    n_mode = brf_pkg::MODE_BISECT;
                    n_c    = mid_ab;
                    n_pend = '{brf_pkg::KIND_QUERY, mid_ab, 16'd0, 1'b0};
                end else begin
                    n_state = S_B0;
                end
            end
            S_BIS: begin
                if (r_fv == '0) begin
                    n_pend  = '{brf_pkg::KIND_ROOT, r_c, 16'd0, 1'b0};
                    n_state = S_EMIT;
                end else begin
                    if ((brf_pkg::is_pos(r_fa) && r_fv[63]) ||
                        (r_fa[63] && brf_pkg::is_pos(r_fv))) begin
                        n_b  = r_c;
                        n_fb = r_fv;
                    end else begin
                        n_a  = r_c;
                        n_fa = r_fv;
                    end
                    n_state = S_BIS2;
                end
            end
            S_BIS2: begin
                n_state = S_EMIT;
                if (brf_pkg::udist(r_a, r_b) <= {1'b0, r_tol}) begin
                    n_pend = '{brf_pkg::KIND_ROOT, mid_ab, 16'd0, 1'b0};
                end else begin
                    n_iter = iter_inc;
                    if (iter_inc >= lim_bis) begin
                        n_pend = '{brf_pkg::KIND_ROOT, mid_ab, 16'd0, 1'b0};
                    end else begin
                        n_c    = mid_ab;
                        n_pend = '{brf_pkg::KIND_QUERY, mid_ab, 16'd0, 1'b0};
                    end
                end
            end
            S_BRCHK: begin
                if (r_iter >= lim_brent) begin
                    n_pend  = '{brf_pkg::KIND_ROOT, r_b, 16'd0, 1'b0};
                    n_state = S_EMIT;
                end else begin
                    n_state = S_B0;
                end
            end
            S_B0: begin
                // b and c on the same side: c takes the old point
                if (brf_pkg::same_sign(r_fb, r_fc)) begin
                    n_c  = r_a;
                    n_fc = r_fa;
                    n_d  = brf_pkg::ssub(r_b, r_a);
                    n_e  = brf_pkg::ssub(r_b, r_a);
                end
                n_state = S_B1;
            end
            S_B1: begin
                // keep the best estimate in b
                if (brf_pkg::mag(r_fc) < brf_pkg::mag(r_fb)) begin
                    n_a  = r_b;
                    n_b  = r_c;
                    n_c  = r_b;
                    n_fa = r_fb;
                    n_fb = r_fc;
                    n_fc = r_fb;
                end
                n_state = S_B2;
            end
            S_B2: begin
                n_xm    = brf_pkg::half_diff(r_c, r_b);
                n_state = S_B3;
            end
            S_B3: begin
                if (brf_pkg::mag(r_xm) <= tol1 || r_fb == '0) begin
                    n_pend  = '{brf_pkg::KIND_ROOT, r_b, r_iter, 1'b1};
                    n_state = S_EMIT;
                end else if (brf_pkg::mag(r_e) >= tol1 &&
                             brf_pkg::mag(r_fa) > brf_pkg::mag(r_fb)) begin
                    n_state = S_DS;
                end else begin
                    n_d     = r_xm;
                    n_e     = r_xm;
                    n_state = S_FIN;
                end
            end
            S_DS: begin
                if (step_done) begin
                    n_s     = alu_res;
                    n_state = (r_a == r_c) ? S_P0 : S_DQ1;
                end
            end
            S_P0: begin
                // secant
                if (step_done) begin
                    n_p     = alu_res;
                    n_q     = brf_pkg::ssub(Q_ONE, r_s);
                    n_state = S_SIGN;
                end
            end
            S_DQ1: begin
                if (step_done) begin
                    n_q1 = alu_res; n_state = S_DR;
                end
            end
            S_DR: begin
                if (step_done) begin
                    n_rr = alu_res; n_state = S_M1;
                end
            end
            S_M1: begin
                if (step_done) begin
                    n_t = alu_res; n_state = S_M2;
                end
            end
            S_M2: begin
                if (step_done) begin
                    n_t = alu_res; n_state = S_M3;
                end
            end
            S_M3: begin
                if (step_done) begin
                    n_p = alu_res; n_state = S_M4;
                end
            end
            S_M4: begin
                if (step_done) begin
                    n_p = alu_res; n_state = S_M5;
                end
            end
            S_M5: begin
                if (step_done) begin
                    n_q = alu_res; n_state = S_M6;
                end
            end
            S_M6: begin
                if (step_done) begin
                    n_q = alu_res; n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                if (brf_pkg::is_pos(r_p)) begin
                    n_q = brf_pkg::sneg(r_q);
                end else begin
                    n_p = brf_pkg::sneg(r_p);
                end
                n_state = S_L1;
            end
            S_L1: begin
                if (step_done) begin
                    n_t = alu_res; n_state = S_L2;
                end
            end
            S_L2: begin
                if (step_done) begin
                    n_lim1  = brf_pkg::ssub(r_t, brf_pkg::sabs(alu_res));
                    n_state = S_L3;
                end
            end
            S_L3: begin
                if (step_done) begin
                    n_t     = brf_pkg::sabs(alu_res);
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // accept the interpolation or fall back to bisection
                if (pp < lim_min) begin
                    n_e     = r_d;
                    n_state = S_DD;
                end else begin
                    n_d     = r_xm;
                    n_e     = r_xm;
                    n_state = S_FIN;
                end
            end
            S_DD: begin
                if (step_done) begin
                    n_d = alu_res; n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_a     = r_b;
                n_fa    = r_fb;
                n_b     = new_b;
                n_mode  = brf_pkg::MODE_BRENT;
                n_pend  = '{brf_pkg::KIND_QUERY, new_b, 16'd0, 1'b0};
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_pend.kind == brf_pkg::KIND_ROOT) begin
                    n_mode = brf_pkg::MODE_IDLE;
                end
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_pend;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= brf_pkg::MODE_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
            r_tol    <= 63'd4295;
            r_maxit  <= 16'd0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_wait   <= n_wait;
            r_ovalid <= n_ovalid;
            r_tol    <= n_tol;
            r_maxit  <= n_maxit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a  <= n_a;  r_b  <= n_b;  r_c  <= n_c;
        r_fa <= n_fa; r_fb <= n_fb; r_fc <= n_fc;
        r_d  <= n_d;  r_e  <= n_e;
        r_xm <= n_xm; r_s  <= n_s;  r_q1 <= n_q1; r_rr <= n_rr;
        r_t  <= n_t;  r_p  <= n_p;  r_q  <= n_q;  r_lim1 <= n_lim1;
        r_fv <= n_fv;
        r_iter  <= n_iter;
        r_pend  <= n_pend;
        r_odata <= n_odata;
    end

    // the unit only answers an operation this sequencer is waiting on
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> r_wait)
        else $error("alu done without a pending operation");

    // a root result ends the search
    a_root_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_pend.kind == brf_pkg::KIND_ROOT)
        |=> (r_mode == brf_pkg::MODE_IDLE))
        else $error("search still active after root");

    // a convergence count only comes with a root
    a_count_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odata.iterations_valid) |-> (r_odata.kind == brf_pkg::KIND_ROOT))
        else $error("iteration count on a query beat");

    // no new beat taken while the unit is mid-operation
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait |-> !i_item.ready)
        else $error("input ready during arithmetic");

endmodule

`default_nettype wire

// ===== tb/sv/brf_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brf_checker
// Watches the item, result and config ports of the root finder, predicts each
// result beat from the accepted item beats and compares field by field.
// ----------------------------------------------------------------------------

module brf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brf_in_if           item_ch,
    brf_out_if          result_ch,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [62:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int FB = 32;
    localparam brf_pkg::t_word ONE_Q = brf_pkg::t_word'(64'd1 << FB);
    localparam brf_pkg::t_word POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam brf_pkg::t_word NEG_MIN = 64'sh8000_0000_0000_0000;

    brf_pkg::t_word pa, pb, pc, fa, fb, fc, stp_d, stp_e;
    brf_pkg::t_mode mode;
    logic [15:0]    iters;
    logic [62:0]    tol_reg;
    logic [15:0]    iter_lim_reg;

    brf_pkg::t_out_beat expected_q[$];
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    function automatic brf_pkg::t_word clip65(input logic signed [64:0] v);
        if (v > 65'sh0_7FFF_FFFF_FFFF_FFFF) return POS_MAX;
        if (v < -65'sh0_8000_0000_0000_0000) return NEG_MIN;
        return v[63:0];
    endfunction

    function automatic brf_pkg::t_word add_s(input brf_pkg::t_word a, input brf_pkg::t_word b);
        return clip65(65'(a) + 65'(b));
    endfunction

    function automatic brf_pkg::t_word sub_s(input brf_pkg::t_word a, input brf_pkg::t_word b);
        return clip65(65'(a) - 65'(b));
    endfunction

    function automatic brf_pkg::t_word neg_s(input brf_pkg::t_word x);
        return (x == NEG_MIN) ? POS_MAX : -x;
    endfunction

    function automatic brf_pkg::t_word abs_s(input brf_pkg::t_word x);
        return x < 0 ? neg_s(x) : x;
    endfunction

    function automatic logic [63:0] absu(input brf_pkg::t_word x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic brf_pkg::t_word from_mag(input logic neg, input logic [63:0] m);
        logic [63:0] c;
        c = m[63] ? 64'(POS_MAX) : m;
        return neg ? -brf_pkg::t_word'(c) : brf_pkg::t_word'(c);
    endfunction

    function automatic brf_pkg::t_word avg_floor(input brf_pkg::t_word a,
                                                 input brf_pkg::t_word b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        return brf_pkg::t_word'(s >>> 1);
    endfunction

    function automatic brf_pkg::t_word half_gap(input brf_pkg::t_word c,
                                                input brf_pkg::t_word b);
        logic signed [64:0] s;
        s = 65'(c) - 65'(b);
        return brf_pkg::t_word'(s >>> 1);
    endfunction

    function automatic logic [63:0] gap_u(input brf_pkg::t_word a, input brf_pkg::t_word b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        return s < 0 ? 64'(-s) : 64'(s);
    endfunction

    function automatic brf_pkg::t_word q_mul(input brf_pkg::t_word x, input brf_pkg::t_word y);
        logic [127:0] p;
        logic [63:0]  r;
        p = absu(x) * absu(y);
        r = (p[127:64+FB] != '0) ? '1 : p[63+FB:FB];
        return from_mag((x < 0) != (y < 0), r);
    endfunction

    function automatic brf_pkg::t_word q_div(input brf_pkg::t_word n, input brf_pkg::t_word d);
        logic [63:0]  un, ud;
        logic [127:0] q;
        logic         neg;
        un  = absu(n);
        ud  = absu(d);
        neg = (n < 0) != (d < 0);
        if (un == 0) return '0;
        if (ud == 0 || (un >> (64 - FB)) >= ud) return from_mag(neg, '1);
        q = {64'd0, un} << FB;
        q = q / {64'd0, ud};
        return from_mag(neg, q[63:0]);
    endfunction

    function automatic logic both_same(input brf_pkg::t_word a, input brf_pkg::t_word b);
        return (a > 0 && b > 0) || (a < 0 && b < 0);
    endfunction

    function automatic int lim_of(input int dflt);
        return iter_lim_reg != 0 ? int'(iter_lim_reg) : dflt;
    endfunction

    function automatic brf_pkg::t_out_beat mk_res(input logic k, input brf_pkg::t_word pt,
                                                  input logic [15:0] it, input logic v);
        brf_pkg::t_out_beat r;
        r.kind             = k;
        r.point            = pt;
        r.iterations       = v ? it : 16'd0;
        r.iterations_valid = v;
        if (k == brf_pkg::KIND_ROOT) mode = brf_pkg::MODE_IDLE;
        return r;
    endfunction

    // one Brent step: swap, convergence test, interpolation or bisection
    function automatic brf_pkg::t_out_beat brent_step();
        brf_pkg::t_word tol1, xm, p, q, s, q1, r, t1, t2, l1, l2;
        tol1 = brf_pkg::t_word'(64'd1 + (64'(tol_reg) >> 1));
        if (both_same(fb, fc)) begin
            pc = pa; fc = fa;
            stp_d = sub_s(pb, pa); stp_e = stp_d;
        end
        if (absu(fc) < absu(fb)) begin
            pa = pb; pb = pc; pc = pa;
            fa = fb; fb = fc; fc = fa;
        end
        xm = half_gap(pc, pb);
        if (absu(xm) <= 64'(tol1) || fb == 0)
            return mk_res(brf_pkg::KIND_ROOT, pb, iters, 1'b1);
        if (absu(stp_e) >= 64'(tol1) && absu(fa) > absu(fb)) begin
            s = q_div(fb, fa);
            if (pa == pc) begin
                p = q_mul(add_s(xm, xm), s);
                q = sub_s(ONE_Q, s);
            end else begin
                q1 = q_div(fa, fc);
                r  = q_div(fb, fc);
                t1 = q_mul(q_mul(add_s(xm, xm), q1), sub_s(q1, r));
                t2 = q_mul(sub_s(pb, pa), sub_s(r, ONE_Q));
                p  = q_mul(s, sub_s(t1, t2));
                q  = q_mul(q_mul(sub_s(q1, ONE_Q), sub_s(r, ONE_Q)), sub_s(s, ONE_Q));
            end
            if (p > 0) q = neg_s(q);
            else p = neg_s(p);
            l1 = sub_s(q_mul(add_s(add_s(xm, xm), xm), q), abs_s(q_mul(tol1, q)));
            l2 = abs_s(q_mul(stp_e, q));
            if (add_s(p, p) < (l1 < l2 ? l1 : l2)) begin
                stp_e = stp_d; stp_d = q_div(p, q);
            end else begin
                stp_d = xm; stp_e = xm;
            end
        end else begin
            stp_d = xm; stp_e = xm;
        end
        pa = pb; fa = fb;
        if (absu(stp_d) > 64'(tol1)) pb = add_s(pb, stp_d);
        else pb = add_s(pb, xm > 0 ? tol1 : -tol1);
        mode = brf_pkg::MODE_BRENT;
        return mk_res(brf_pkg::KIND_QUERY, pb, 16'd0, 1'b0);
    endfunction

    // returns 1 and the predicted beat when the item causes a result
    function automatic logic predict_next(input brf_pkg::t_in_beat b,
                                          output brf_pkg::t_out_beat r);
        brf_pkg::t_word fv;
        if (b.op == brf_pkg::OP_START) begin
            pa = b.x_low; pb = b.x_high; fa = b.f_low; fb = b.f_high;
            pc = pb; fc = fb;
            stp_d = '0; stp_e = '0; iters = '0;
            if (fa == 0) begin
                r = mk_res(brf_pkg::KIND_ROOT, pa, 16'd0, 1'b0); return 1;
            end
            if (fb == 0) begin
                r = mk_res(brf_pkg::KIND_ROOT, pb, 16'd0, 1'b0); return 1;
            end
            if (both_same(fa, fb)) begin
                mode = brf_pkg::MODE_BISECT;
                pc = avg_floor(pa, pb);
                r = mk_res(brf_pkg::KIND_QUERY, pc, 16'd0, 1'b0);
                return 1;
            end
            r = brent_step();
            return 1;
        end
        fv = b.f_value;
        if (mode == brf_pkg::MODE_BISECT) begin
            if (fv == 0) begin
                r = mk_res(brf_pkg::KIND_ROOT, pc, 16'd0, 1'b0); return 1;
            end
            if ((fa > 0 && fv < 0) || (fa < 0 && fv > 0)) begin
                pb = pc; fb = fv;
            end else begin
                pa = pc; fa = fv;
            end
            if (gap_u(pa, pb) <= 64'(tol_reg)) begin
                r = mk_res(brf_pkg::KIND_ROOT, avg_floor(pa, pb), 16'd0, 1'b0);
                return 1;
            end
            iters++;
            if (int'(iters) >= lim_of(50)) begin
                r = mk_res(brf_pkg::KIND_ROOT, avg_floor(pa, pb), 16'd0, 1'b0);
                return 1;
            end
            pc = avg_floor(pa, pb);
            r = mk_res(brf_pkg::KIND_QUERY, pc, 16'd0, 1'b0);
            return 1;
        end
        if (mode == brf_pkg::MODE_BRENT) begin
            fb = fv;
            iters++;
            if (int'(iters) >= lim_of(100)) begin
                r = mk_res(brf_pkg::KIND_ROOT, pb, 16'd0, 1'b0);
                return 1;
            end
            r = brent_step();
            return 1;
        end
        return 0;   // reply with no search running
    endfunction

    task automatic report(input string what, input brf_pkg::t_out_beat exp_b,
                          input brf_pkg::t_out_beat got_b);
        $display("[%0t] mismatch %s: exp k=%0d pt=%h it=%0d v=%0d got k=%0d pt=%h it=%0d v=%0d",
                 $realtime, what, exp_b.kind, exp_b.point, exp_b.iterations,
                 exp_b.iterations_valid, got_b.kind, got_b.point, got_b.iterations,
                 got_b.iterations_valid);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        brf_pkg::t_out_beat pr, ex, got;
        if (!i_rst_n) begin
            pa = '0; pb = '0; pc = '0; fa = '0; fb = '0; fc = '0;
            stp_d = '0; stp_e = '0; mode = brf_pkg::MODE_IDLE; iters = '0;
            tol_reg = 63'd4295; iter_lim_reg = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == brf_pkg::CFG_TOLERANCE) tol_reg = i_cfg_data;
                else iter_lim_reg = i_cfg_data[15:0];
            end
            if (item_ch.valid && item_ch.ready) begin
                if (predict_next(item_ch.data, pr)) expected_q.push_back(pr);
            end
            if (result_ch.valid && result_ch.ready) begin
                got = result_ch.data;
                if (expected_q.size() == 0) begin
                    ex = '0;
                    report("unexpected beat", ex, got);
                end else begin
                    ex = expected_q.pop_front();
                    if (got.kind !== ex.kind) report("kind", ex, got);
                    if (got.point !== ex.point) report("point", ex, got);
                    if (got.iterations !== ex.iterations) report("iterations", ex, got);
                    if (got.iterations_valid !== ex.iterations_valid)
                        report("iterations_valid", ex, got);
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_brent_root_finder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_brent_root_finder_core
// Drives root searches on a synthetic linear function through the item port,
// answers each query beat, sweeps both registers and lets the checker score.
// ----------------------------------------------------------------------------

module tb_brent_root_finder_core;

    localparam int IDLE_LIMIT = 40000;   // cycles without any beat
    localparam int N_ITEMS    = 1000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [62:0] cfg_data;
    int          fail_count;
    int          pending;

    brf_in_if  item_ch ();
    brf_out_if result_ch ();

    brent_root_finder_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    brf_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item_ch      (item_ch),
        .result_ch    (result_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // stretch with no idling on either side
    logic quiet;
    int   n_sent;

    // result side backpressure, ~24% stall outside the quiet stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) result_ch.ready <= 1'b0;
        else result_ch.ready <= quiet || ($urandom_range(99) >= 24);
    end

    // result beats seen by the stimulus side, in beat order
    brf_pkg::t_out_beat seen_q[$];
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) seen_q.push_back(result_ch.data);
    end

    // watchdog on cycles with no beat on either channel
    int stall_cycles;
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // synthetic function f(x) = +-(x - root) >>> shift, saturated
    brf_pkg::t_word fn_root;
    int             fn_shift;
    logic           fn_flip;

    function automatic brf_pkg::t_word rand64();
        return brf_pkg::t_word'({$urandom, $urandom});
    endfunction

    function automatic brf_pkg::t_word rand_small();
        // mostly within +-2^40 so intervals stay reasonable
        return brf_pkg::t_word'($signed({$urandom, $urandom}) >>> $urandom_range(63, 20));
    endfunction

    function automatic brf_pkg::t_word eval_fn(input brf_pkg::t_word x);
        logic signed [64:0] d;
        d = 65'(x) - 65'(fn_root);
        d = d >>> fn_shift;
        if (fn_flip) d = -d;
        if (d > 65'sh0_7FFF_FFFF_FFFF_FFFF) return brf_pkg::SMAX;
        if (d < -65'sh0_8000_0000_0000_0000) return brf_pkg::SMIN;
        return d[63:0];
    endfunction

    // one item beat; caller sits at a rising edge, valid is low on return
    task automatic send_beat(input brf_pkg::t_in_beat b);
        if (!quiet && $urandom_range(99) < 24) repeat ($urandom_range(6, 1)) @(posedge i_clk);
        item_ch.valid <= 1'b1;
        item_ch.data  <= b;
        do @(posedge i_clk); while (!item_ch.ready);
        item_ch.valid <= 1'b0;
        n_sent++;
    endtask

    task automatic wait_result(output brf_pkg::t_out_beat r);
        while (seen_q.size() == 0) @(posedge i_clk);
        r = seen_q.pop_front();
    endtask

    task automatic write_reg(input logic idx, input logic [62:0] val);
        repeat (20) @(posedge i_clk);    // let an ignored reply drain
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic brf_pkg::t_in_beat mk_start(input brf_pkg::t_word xl,
                                                   input brf_pkg::t_word xh,
                                                   input brf_pkg::t_word fl,
                                                   input brf_pkg::t_word fh);
        brf_pkg::t_in_beat b;
        b        = '0;
        b.op     = brf_pkg::OP_START;
        b.x_low  = xl;
        b.x_high = xh;
        b.f_low  = fl;
        b.f_high = fh;
        b.f_value = rand64();    // don't-care on start, random to toggle bits
        return b;
    endfunction

    function automatic brf_pkg::t_in_beat mk_reply(input brf_pkg::t_word fv);
        brf_pkg::t_in_beat b;
        b         = '0;
        b.op      = brf_pkg::OP_REPLY;
        b.x_low   = rand64();
        b.x_high  = rand64();
        b.f_low   = rand64();
        b.f_high  = rand64();
        b.f_value = fv;
        return b;
    endfunction

    // start a search and answer queries until root or reply cap (abandon)
    task automatic run_search(input brf_pkg::t_in_beat st, input int max_replies,
                              input int noise_pct, output logic done);
        brf_pkg::t_out_beat r;
        int                 k;
        send_beat(st);
        done = 1'b0;
        k = 0;
        forever begin
            wait_result(r);
            if (r.kind == brf_pkg::KIND_ROOT) begin
                done = 1'b1;
                break;
            end
            if (k >= max_replies) break;
            if ($urandom_range(99) < noise_pct) send_beat(mk_reply(rand64()));
            else send_beat(mk_reply(eval_fn(r.point)));
            k++;
        end
    endtask

    // random root, slope shift and sign for the synthetic function
    task automatic pick_fn();
        fn_root  = rand_small();
        fn_shift = $urandom_range(8, 0);
        fn_flip  = $urandom_range(1);
    endtask

    function automatic brf_pkg::t_word add_off(input brf_pkg::t_word x);
        logic signed [64:0] s;
        s = 65'(x) + 65'($unsigned(rand_small()) >> 1);
        return s > 65'sh0_7FFF_FFFF_FFFF_FFFF ? brf_pkg::SMAX : s[63:0];
    endfunction

    function automatic brf_pkg::t_word sub_off(input brf_pkg::t_word x);
        logic signed [64:0] s;
        s = 65'(x) - 65'($unsigned(rand_small()) >> 1);
        return s < -65'sh0_8000_0000_0000_0000 ? brf_pkg::SMIN : s[63:0];
    endfunction

    task automatic random_search(output logic done);
        brf_pkg::t_word xl, xh;
        int             sel;
        pick_fn();
        sel = $urandom_range(99);
        if (sel < 65) begin
            // bracket the root
            xl = sub_off(fn_root);
            xh = add_off(fn_root);
            if ($urandom_range(1)) begin
                brf_pkg::t_word t;
                t = xl; xl = xh; xh = t;
            end
        end else if (sel < 85) begin
            // both ends on one side: bisection path
            xl = add_off(fn_root);
            xh = add_off(xl);
        end else begin
            xl = rand64();
            xh = rand64();
        end
        if (sel >= 95)
            run_search(mk_start(xl, xh, rand64(), rand64()), $urandom_range(20, 1), 30, done);
        else
            run_search(mk_start(xl, xh, eval_fn(xl), eval_fn(xh)),
                       $urandom_range(99) < 10 ? $urandom_range(5, 0) : 300,
                       $urandom_range(99) < 10 ? 20 : 2, done);
    endtask

    // register settings visited between searches
    task automatic random_cfg();
        int sel;
        sel = $urandom_range(7);
        case (sel)
            0: write_reg(brf_pkg::CFG_TOLERANCE, 63'd0);
            1: write_reg(brf_pkg::CFG_TOLERANCE, '1);
            2: write_reg(brf_pkg::CFG_TOLERANCE, 63'($urandom_range(100000)));
            3: write_reg(brf_pkg::CFG_TOLERANCE,
                         63'({$urandom, $urandom} >> $urandom_range(62, 1)));
            4: write_reg(brf_pkg::CFG_MAX_ITER, 63'd0);
            5: write_reg(brf_pkg::CFG_MAX_ITER, 63'($urandom_range(8, 1)));
            6: write_reg(brf_pkg::CFG_MAX_ITER, 63'd65535);
            default: write_reg(brf_pkg::CFG_MAX_ITER, 63'({$urandom, $urandom}));
        endcase
    endtask

    initial begin
        logic               done;
        int                 n_search;
        brf_pkg::t_out_beat zero_root;
        i_rst_n         = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        cfg_we          = 1'b0;
        cfg_idx         = brf_pkg::CFG_TOLERANCE;
        cfg_data        = '0;
        quiet           = 1'b0;
        n_sent          = 0;
        stall_cycles    = 0;
        fn_root         = '0;
        fn_shift        = 0;
        fn_flip         = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        // reply with no search running: no beat back
        send_beat(mk_reply(brf_pkg::SMAX));
        @(posedge i_clk);
        // zero at the low end, then at the high end
        run_search(mk_start(brf_pkg::SMIN, brf_pkg::SMAX, '0, brf_pkg::SMAX), 0, 0, done);
        run_search(mk_start(brf_pkg::SMAX, brf_pkg::SMIN, brf_pkg::SMIN, '0), 0, 0, done);
        // extreme ends, opposite signs, on f(x) = x
        fn_root = '0; fn_shift = 0; fn_flip = 1'b0;
        run_search(mk_start(brf_pkg::SMIN, brf_pkg::SMAX, brf_pkg::SMIN, brf_pkg::SMAX),
                   300, 0, done);
        // same sign: bisection under the default iteration limit
        run_search(mk_start(brf_pkg::SMAX, 64'sh1_0000_0000, brf_pkg::SMAX, 64'sd1),
                   300, 0, done);
        // bisection hit of an exact zero
        fn_root = 64'sh8_0000_0000;
        run_search(mk_start(64'sh10_0000_0000, 64'sh0, 64'sh1, 64'sh1), 1, 0, done);
        if (!done) begin
            send_beat(mk_reply('0));
            wait_result(zero_root);    // root of an exact zero
        end
        // max_iterations extremes and tolerance extremes
        write_reg(brf_pkg::CFG_MAX_ITER, 63'd1);
        run_search(mk_start(-64'sh100_0000_0000, 64'sh100_0000_0000,
                            eval_fn(-64'sh100_0000_0000), eval_fn(64'sh100_0000_0000)),
                   300, 0, done);
        run_search(mk_start(64'sh1, 64'sh100, 64'sh5, 64'sh7), 300, 0, done);
        write_reg(brf_pkg::CFG_TOLERANCE, '1);
        run_search(mk_start(64'sh1, 64'sh100, 64'sh5, 64'sh7), 300, 0, done);
        write_reg(brf_pkg::CFG_TOLERANCE, 63'd0);
        write_reg(brf_pkg::CFG_MAX_ITER, 63'd65535);
        run_search(mk_start(-64'sh3_0000_0000, 64'sh7_1234_5678, eval_fn(-64'sh3_0000_0000),
                            eval_fn(64'sh7_1234_5678)), 300, 0, done);
        // start while a search is running: drop after two replies
        run_search(mk_start(brf_pkg::SMIN, 64'sh5, -64'sd1, 64'sd3), 2, 0, done);
        run_search(mk_start(64'sh0, 64'sh40_0000_0000, 64'sh1, brf_pkg::SMIN), 300, 0, done);
        if (!done) begin
            run_search(mk_start(64'sh0, 64'sh1, 64'sd0, 64'sd1), 0, 0, done);
        end
        write_reg(brf_pkg::CFG_MAX_ITER, 63'd0);
        write_reg(brf_pkg::CFG_TOLERANCE, 63'd4295);

        // ---- random ----
        n_search = 0;
        while (n_sent < N_ITEMS) begin
            quiet = (n_sent > 300 && n_sent < 450);
            random_search(done);
            n_search++;
            if (done && $urandom_range(99) < 8) begin
                @(posedge i_clk);
                send_beat(mk_reply(rand64()));   // stray reply, search is idle
                @(posedge i_clk);
            end
            if (!done) begin
                // close the abandoned search so the block is idle for a write
                run_search(mk_start(64'sh0, 64'sh1, 64'sd0, 64'sd1), 0, 0, done);
            end
            if (n_search % 6 == 0) random_cfg();
        end

        // ---- drain ----
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
